/* design/pulse_frequency_duty_meter_macros.svh */
// Assertion macros shared by the pulse frequency and duty meter modules.
`ifndef PULSE_FREQUENCY_DUTY_METER_MACROS_SVH
`define PULSE_FREQUENCY_DUTY_METER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising clock edge outside of reset.
`define PFDM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfdm: implication check failed");
// Next-cycle implication, checked on the rising clock edge outside of reset.
`define PFDM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pfdm: next-cycle check failed");
`else
`define PFDM_ASSERT_IMP(label, ante, cons)
`define PFDM_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* design/pfdm_pkg.sv */
// Shared widths, constants and types of the pulse frequency and duty meter.
package pfdm_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned RateW   = 30;
  localparam int unsigned PeriodW = TimeW + 1;
  localparam int unsigned DutyW   = 14;
  localparam int unsigned ScaleW  = 14;
  localparam int unsigned ProdW   = TimeW + ScaleW;
  localparam int unsigned StepW   = $clog2(RateW + 1);

  localparam logic [ScaleW-1:0] DutyScale = ScaleW'(10000);
  localparam logic [RateW-1:0]  RateReset = RateW'(10000000);

  // Quotient bits produced for each of the two divisions.
  localparam logic [StepW-1:0] FreqSteps = StepW'(RateW);
  localparam logic [StepW-1:0] DutySteps = StepW'(DutyW);

  localparam logic [1:0] PhaseRise0 = 2'd0;
  localparam logic [1:0] PhaseFall  = 2'd1;
  localparam logic [1:0] PhaseRise1 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FREQ,
    ST_DUTY,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic               start;
    logic [PeriodW-1:0] rem_init;
    logic [RateW-1:0]   dividend;
    logic [StepW-1:0]   steps;
    logic [PeriodW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RateW-1:0] quotient;
  } div_rsp_t;

endpackage

/* design/pulse_frequency_duty_meter.sv */
// Top level of the pulse frequency and duty meter with its sequencer and ports.
// Each input word is one capture timestamp of the measured signal, in the
// order rising, falling, rising edge. The first two words of a cycle are
// absorbed and give no output, unless the falling stamp equals the rising
// one. The closing rising edge yields one output word with the high and low
// tick counts, the frequency tick_rate_hz / (high + low) and the duty cycle in
// hundredths of a percent, truncated. Time differences wrap modulo 2^32. A
// falling or closing edge whose timestamp equals the one before gives an output
// word with timing_error set and all other fields zero, and measurement
// restarts with a rising edge. A closing edge passes through these steps:
// accept, the high-time scaling multiply while the frequency division starts,
// frequency division (30 quotient bits, then a hand-over to the duty
// division), duty division (14 quotient bits, then a report of completion)
// and, once the output register is free, the hand-over of the result to it.
// An edge with equal timestamps is accepted and then loads the error word.
// Both divisions run on one shared restoring divider that retires one
// quotient bit per cycle. s_axis_tready is low while the block is busy. The
// output register holds a finished word until it is taken, while the block
// already accepts the next timestamp. The tick rate register lives at byte
// address 0 of the APB port and resets to 10 MHz; it may be written only
// while no measurement is in flight.
`include "pulse_frequency_duty_meter_macros.svh"
module pulse_frequency_duty_meter (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Capture stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] edge_time
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,   // [31:0] high_ticks, [63:32] low_ticks,
                                       // [93:64] frequency_hz,
                                       // [107:94] duty_hundredths, rest zero
  output logic [0:0]   m_axis_tuser,   // [0] timing_error
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import pfdm_pkg::*;

  state_e state_q, state_d;

  logic [RateW-1:0]   rate_q;
  logic [1:0]         phase_q;
  logic [TimeW-1:0]   last_q;
  logic [TimeW-1:0]   high_q;
  logic [TimeW-1:0]   low_q;
  logic [PeriodW-1:0] period_q;
  logic [ProdW-1:0]   prod_q;
  logic [RateW-1:0]   freq_q;
  logic               err_q;

  logic               out_valid_q;
  logic [TimeW-1:0]   out_high_q;
  logic [TimeW-1:0]   out_low_q;
  logic [RateW-1:0]   out_freq_q;
  logic [DutyW-1:0]   out_duty_q;
  logic               out_err_q;

  logic               accept;
  logic               out_free;
  logic               load_out;
  logic [TimeW-1:0]   edge_time;
  logic [TimeW-1:0]   diff;
  logic               diff_zero;
  logic               cfg_write;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign edge_time = s_axis_tdata;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign diff      = edge_time - last_q;
  assign diff_zero = (diff == '0);
  assign out_free  = !out_valid_q || m_axis_tready;

  // Configuration port: a single register, writes to other words are dropped.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
  assign prdata    = paddr[2] ? '0 : {{(32 - RateW){1'b0}}, rate_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RateReset;
    end else if (cfg_write) begin
      rate_q <= pwdata[RateW-1:0];
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (phase_q == PhaseFall) && diff_zero) begin
          state_d = ST_LOAD;
        end else if (accept && (phase_q == PhaseRise1)) begin
          state_d = diff_zero ? ST_LOAD : ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_FREQ;
      ST_FREQ: begin
        if (div_rsp.done) begin
          state_d = ST_DUTY;
        end
      end
      ST_DUTY: begin
        if (div_rsp.done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs and divider requests. The frequency division starts
  // while the product is being formed; the duty division follows on the
  // scaled high time, whose quotient is known to stay below 2^14, so only
  // its low 14 bits are shifted through the divider.
  always_comb begin
    s_axis_tready    = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.rem_init = '0;
    div_req.dividend = rate_q;
    div_req.steps    = FreqSteps;
    div_req.divisor  = period_q;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_MUL:  div_req.start = 1'b1;
      ST_FREQ: begin
        div_req.start    = div_rsp.done;
        div_req.rem_init = PeriodW'(prod_q[ProdW-1:DutyW]);
        div_req.dividend = {prod_q[DutyW-1:0], {(RateW - DutyW){1'b0}}};
        div_req.steps    = DutySteps;
      end
      ST_DUTY: ;
      ST_LOAD: load_out = out_free;
      default: ;
    endcase
  end

  pfdm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Edge phase tracking and measurement registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PhaseRise0;
      last_q  <= '0;
      high_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        case (phase_q)
          PhaseFall: begin
            if (diff_zero) begin
              err_q   <= 1'b1;
              phase_q <= PhaseRise0;
            end else begin
              high_q  <= diff;
              last_q  <= edge_time;
              phase_q <= PhaseRise1;
            end
          end
          PhaseRise1: begin
            err_q   <= diff_zero;
            phase_q <= PhaseRise0;
          end
          default: begin
            last_q  <= edge_time;
            phase_q <= PhaseFall;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (phase_q == PhaseRise1)) begin
      low_q    <= diff;
      period_q <= {1'b0, high_q} + {1'b0, diff};
    end
    if (state_q == ST_MUL) begin
      prod_q <= ProdW'(high_q) * ProdW'(DutyScale);
    end
    if (state_q == ST_FREQ && div_rsp.done) begin
      freq_q <= div_rsp.quotient;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_err_q  <= err_q;
      out_high_q <= err_q ? '0 : high_q;
      out_low_q  <= err_q ? '0 : low_q;
      out_freq_q <= err_q ? '0 : freq_q;
      out_duty_q <= err_q ? '0 : div_rsp.quotient[DutyW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(112 - 2 * TimeW - RateW - DutyW){1'b0}},
                          out_duty_q, out_freq_q, out_low_q, out_high_q};
  assign m_axis_tuser  = out_err_q;

  `PFDM_ASSERT_IMP(a_err_word_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
  `PFDM_ASSERT_IMP(a_duty_in_range, m_axis_tvalid && !m_axis_tuser[0],
                   m_axis_tdata[107:94] <= DutyW'(10000))
  `PFDM_ASSERT_IMP(a_no_accept_while_dividing, div_rsp.busy, !s_axis_tready)
  `PFDM_ASSERT_NXT(a_closing_edge_leaves_idle, accept && phase_q == PhaseRise1,
                   state_q != ST_IDLE && phase_q == PhaseRise0)

endmodule

/* design/pfdm_div.sv */
// Shared restoring divider that produces one quotient bit per clock cycle.
`include "pulse_frequency_duty_meter_macros.svh"
module pfdm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfdm_pkg::div_req_t req_i,
  output pfdm_pkg::div_rsp_t rsp_o
);
  import pfdm_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [StepW-1:0]   cnt_q, cnt_d;
  logic [PeriodW-1:0] rem_q, rem_d;
  logic [RateW-1:0]   shf_q, shf_d;
  logic [RateW-1:0]   quo_q, quo_d;
  logic [PeriodW:0]   trial;
  logic               fits;

  // The remainder always stays below the divisor, so the shifted trial fits
  // in one more bit than the divisor.
  assign trial = {rem_q, shf_q[RateW-1]};
  assign fits  = trial >= {1'b0, req_i.divisor};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    shf_d  = shf_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      shf_d  = req_i.dividend;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? PeriodW'(trial - {1'b0, req_i.divisor}) : PeriodW'(trial);
      shf_d = {shf_q[RateW-2:0], 1'b0};
      quo_d = {quo_q[RateW-2:0], fits};
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shf_q <= shf_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `PFDM_ASSERT_IMP(a_rem_below_divisor, busy_q, rem_q < req_i.divisor)
  `PFDM_ASSERT_NXT(a_done_ends_run, busy_q && cnt_q == StepW'(1), done_q && !busy_q)
  `PFDM_ASSERT_IMP(a_no_restart_busy, busy_q, !req_i.start)

endmodule

/* tb/sv/pulse_frequency_duty_meter_checker.sv */
// Checker for the pulse frequency and duty meter: predicts every result word and compares it.
`timescale 1ns / 1ps
module pulse_frequency_duty_meter_checker
  import pfdm_pkg::*;
#(
  parameter logic [2:0] RateAddr = 3'd0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] edge_time
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,   // [31:0] high_ticks, [63:32] low_ticks,
                                       // [93:64] frequency_hz,
                                       // [107:94] duty_hundredths, rest zero
  input  logic [0:0]   m_axis_tuser,   // [0] timing_error
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           error_count_o,
  output int           owed_results_o,
  output logic [1:0]   phase_o
);

  typedef struct packed {
    logic [TimeW-1:0] high_ticks;
    logic [TimeW-1:0] low_ticks;
    logic [RateW-1:0] frequency_hz;
    logic [DutyW-1:0] duty_hundredths;
    logic             timing_error;
  } reading_t;

  logic [RateW-1:0] tick_rate;
  logic [1:0]       meas_phase;
  logic [TimeW-1:0] stored_stamp;
  logic [TimeW-1:0] high_span;
  reading_t         due_readings[$];

  assign phase_o = meas_phase;

  // Advances the measurement by one capture stamp; returns 1 when it closes a reading.
  function automatic bit measure_edge(input logic [TimeW-1:0] stamp, output reading_t res);
    logic [TimeW-1:0] span;
    logic [63:0]      period;
    bit               closed;
    res    = '0;
    closed = 1'b0;
    span   = stamp - stored_stamp;
    case (meas_phase)
      PhaseFall, PhaseRise1: begin
        if (span == '0) begin
          // Two equal stamps: flag the reading and start over at a rising edge.
          res.timing_error = 1'b1;
          meas_phase       = PhaseRise0;
          closed           = 1'b1;
        end else if (meas_phase == PhaseFall) begin
          high_span    = span;
          stored_stamp = stamp;
          meas_phase   = PhaseRise1;
        end else begin
          period              = 64'(high_span) + 64'(span);
          res.high_ticks      = high_span;
          res.low_ticks       = span;
          res.frequency_hz    = RateW'(64'(tick_rate) / period);
          res.duty_hundredths = DutyW'((64'(high_span) * 64'(DutyScale)) / period);
          meas_phase          = PhaseRise0;
          closed              = 1'b1;
        end
      end
      default: begin
        stored_stamp = stamp;
        meas_phase   = PhaseFall;
      end
    endcase
    return closed;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      error_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    reading_t fresh;
    if (!rst_ni) begin
      tick_rate      = RateReset;
      meas_phase     = PhaseRise0;
      stored_stamp   = '0;
      high_span      = '0;
      due_readings.delete();
      error_count_o  = 0;
      owed_results_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == RateAddr) begin
        tick_rate = pwdata[RateW-1:0];
      end
      // Results are taken before new stamps so a word never meets its own expectation early.
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_readings.size() == 0) begin
          $error("result word 0x%0h arrived with no reading due", m_axis_tdata);
          error_count_o++;
        end else begin
          want = due_readings.pop_front();
          check_field("high_ticks", 64'(want.high_ticks), 64'(m_axis_tdata[31:0]));
          check_field("low_ticks", 64'(want.low_ticks), 64'(m_axis_tdata[63:32]));
          check_field("frequency_hz", 64'(want.frequency_hz), 64'(m_axis_tdata[93:64]));
          check_field("duty_hundredths", 64'(want.duty_hundredths),
                      64'(m_axis_tdata[107:94]));
          check_field("timing_error", 64'(want.timing_error), 64'(m_axis_tuser[0]));
          check_field("tdata padding", '0, 64'(m_axis_tdata[111:108]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (measure_edge(s_axis_tdata, fresh)) due_readings.push_back(fresh);
      end
      owed_results_o = due_readings.size();
    end
  end

endmodule

/* tb/sv/pulse_frequency_duty_meter_tb.sv */
// Testbench top for the pulse frequency and duty meter: edge and rate stimulus, verdict.
`timescale 1ns / 1ps
module pulse_frequency_duty_meter_tb;
  import pfdm_pkg::*;

  // Register map: the tick rate sits at byte address 0. Address 4 decodes to no
  // register, so a write there must leave the rate alone.
  localparam logic [2:0]  RateAddr     = 3'd0;
  localparam logic [2:0]  SpareAddr    = 3'd4;
  // Covers the time a closing edge keeps the meter busy, with margin.
  localparam int unsigned DrainCycles  = 64;
  // Longest quiet stretch we tolerate: the longest sink stall on top of the longest
  // source gap and a full division still fits many times over.
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned RateSettings = 9;
  localparam int unsigned DirectedLen  = 23;
  localparam int unsigned PerSetting   = 186;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata  = '0;   // [31:0] edge_time
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;         // [31:0] high_ticks, [63:32] low_ticks,
                                      // [93:64] frequency_hz,
                                      // [107:94] duty_hundredths, rest zero
  logic [0:0]   m_axis_tuser;         // [0] timing_error
  logic         psel          = 1'b0;
  logic         penable       = 1'b0;
  logic         pwrite        = 1'b0;
  logic [2:0]   paddr         = '0;
  logic [31:0]  pwdata        = '0;
  logic [31:0]  prdata;
  logic         pready;

  int           error_count;
  int           owed_results;
  logic [1:0]   meter_phase;

  // Stimulus bookkeeping. The "calm" flags switch off idling for a stretch so that
  // back-to-back traffic gets exercised as well as gappy traffic.
  logic [31:0]  prev_edge  = '0;
  int unsigned  edges_sent = 0;
  bit           feed_calm  = 1'b0;
  bit           sink_calm  = 1'b0;
  int unsigned  sink_hold  = 0;
  int unsigned  quiet_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pulse_frequency_duty_meter DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  pulse_frequency_duty_meter_checker #(
    .RateAddr(RateAddr)
  ) meter_check (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .pready,
    .error_count_o (error_count),
    .owed_results_o(owed_results),
    .phase_o       (meter_phase)
  );

  // Idle length for either side: mostly a few cycles, now and then a long one.
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 70) return $urandom_range(3, 1);
    else if (r < 95) return $urandom_range(20, 4);
    else return $urandom_range(250, 40);
  endfunction

  // Nonzero tick span. Short spans dominate, so periods of a few ticks (and with them
  // the largest frequencies) come up often; near-full-range spans exercise the
  // 33-bit period and the wrap of the counter.
  function automatic logic [31:0] pick_span();
    int unsigned r;
    logic [31:0] s;
    r = $urandom_range(99, 0);
    if (r < 40) s = $urandom_range(16, 1);
    else if (r < 65) s = $urandom_range(5000, 17);
    else if (r < 82) s = $urandom_range(32'h000F_FFFF, 5001);
    else if (r < 95) s = $urandom();
    else if (r < 98) s = 32'hFFFF_FFFF;
    else s = 32'hFFFF_FFFF - $urandom_range(15, 0);
    if (s == '0) s = 32'd1;
    return s;
  endfunction

  // The sink takes words at random, with stalls of random length. tready changes
  // only at the falling edge, once per step.
  always @(negedge clk_i) begin
    if ($urandom_range(199, 0) == 0) sink_calm = !sink_calm;
    if (sink_hold != 0) begin
      m_axis_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!sink_calm && $urandom_range(99, 0) < 20) sink_hold = pick_pause();
    end
  end

  // Watchdog: any word moved on either stream, or a register write, proves progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offers one capture word. Called at a falling edge and returns at the falling edge
  // after the handshake with tvalid still high, so the next word can follow without a
  // bubble; whoever stops feeding lowers tvalid at that same edge.
  task automatic send_edge(input logic [31:0] stamp);
    int unsigned gap;
    if ($urandom_range(49, 0) == 0) feed_calm = !feed_calm;
    gap = (feed_calm || $urandom_range(99, 0) < 55) ? 0 : pick_pause();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
    prev_edge = stamp;
    edges_sent++;
  endtask

  // Feeds arbitrary stamps until the meter waits for a rising edge again. The phase
  // is read at the falling edge, well after the checker has moved on.
  task automatic realign();
    while (meter_phase != PhaseRise0) send_edge($urandom());
  endtask

  // Brings the meter to rest: phase back at the rising edge, every reading delivered,
  // and enough extra cycles for any division still running to finish.
  task automatic go_idle();
    realign();
    s_axis_tvalid <= 1'b0;
    while (owed_results != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random traffic: mostly clean rising/falling/rising triples with random spans,
  // the rest equal-stamp errors on either edge and stray single stamps.
  task automatic random_measurements(input int unsigned goal);
    int unsigned kind;
    int unsigned pick;
    logic [31:0] rise;
    logic [31:0] high;
    while (edges_sent < goal) begin
      kind = $urandom_range(99, 0);
      if (kind < 8) begin
        // Stray stamp: may repeat the previous one or land anywhere.
        send_edge(($urandom_range(1, 0) == 1) ? prev_edge : $urandom());
      end else begin
        realign();
        pick = $urandom_range(99, 0);
        if (pick < 45) rise = $urandom();
        else if (pick < 90) rise = prev_edge + pick_span();
        else rise = prev_edge;  // repeating a stamp at a rising edge is legal
        send_edge(rise);
        if (kind < 16) begin
          send_edge(rise);  // falling edge equal to the rising edge
        end else begin
          high = pick_span();
          send_edge(rise + high);
          if (kind < 22) send_edge(rise + high);  // closing edge equal to falling edge
          else send_edge(rise + high + pick_span());
        end
      end
    end
  endtask

  initial begin
    logic [31:0] directed_edges [DirectedLen];
    logic [31:0] rate_plan [RateSettings];
    logic [31:0] base;
    int unsigned k;

    directed_edges = '{
      // Shortest period at the reset rate: one tick high, one tick low.
      32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
      // One tick high across the counter wrap, then the longest low time.
      32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
      // Longest high time with one tick low: period of 2^32, duty just under 100 %.
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
      // Equal stamps on the falling edge.
      32'h8000_0000, 32'h8000_0000,
      // Equal stamps on the closing edge.
      32'd100, 32'd300, 32'd300,
      // Rising edge equal to the stored stamp is fine; then an ordinary pulse.
      32'd300, 32'd400, 32'd1000,
      // Low time that wraps through zero.
      32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5677,
      // Alternating bit patterns.
      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA
    };

    // Rate extremes first, including bits above the 30-bit register and a zero rate,
    // then the reset value again, 1_000_000_000 and a few random settings.
    rate_plan = '{
      32'd1, 32'h3FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd10_000_000, 32'd1_000_000_000,
      32'd0, 32'd0, 32'd0
    };
    rate_plan[6] = $urandom();
    rate_plan[7] = $urandom_range(50_000_000, 1000);
    rate_plan[8] = $urandom();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_edges[i]) send_edge(directed_edges[i]);

    for (k = 0; k < RateSettings; k++) begin
      go_idle();
      write_register(RateAddr, rate_plan[k]);
      // An unmapped address must not disturb the rate just written.
      if (k == 4) begin
        @(negedge clk_i);
        write_register(SpareAddr, $urandom());
      end
      // Largest and smallest frequency at this rate: period 2, then period 2^32.
      base = $urandom();
      send_edge(base);
      send_edge(base + 32'd1);
      send_edge(base + 32'd2);
      send_edge(32'h0000_0000);
      send_edge(32'hFFFF_FFFF);
      send_edge(32'h0000_0000);
      random_measurements(DirectedLen + (k + 1) * PerSetting);
    end

    go_idle();
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* pulse_frequency_duty_meter.f */
+incdir+design
design/pfdm_pkg.sv
design/pfdm_div.sv
design/pulse_frequency_duty_meter.sv
tb/sv/pulse_frequency_duty_meter_checker.sv
tb/sv/pulse_frequency_duty_meter_tb.sv
